// ----- sv/tick_compare_and_time_converter_defines.svh -----
// ----------------------------------------------------------------------------
// tick_compare_and_time_converter_defines.svh
// Assertion macros used by the property checker of the timer block.
// ----------------------------------------------------------------------------
`ifndef TICK_COMPARE_AND_TIME_CONVERTER_DEFINES_SVH
`define TICK_COMPARE_AND_TIME_CONVERTER_DEFINES_SVH

// same-cycle implication
`define TCTC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tctc property failed");

// next-cycle implication
`define TCTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tctc property failed");

`endif

// ----- sv/tctc_pkg.sv -----
// ----------------------------------------------------------------------------
// tctc_pkg
// Types, codes and constants of the tick compare and time converter.
// ----------------------------------------------------------------------------
package tctc_pkg;

  localparam int unsigned TICK_RATE_DEF = 1000;

  localparam logic [31:0] FREQ_RESET = 32'd10_000_000;
  localparam logic [29:0] NS_PER_SEC = 30'd1_000_000_000;

  localparam int unsigned DIV_W  = 64;
  localparam int unsigned DVR_W  = 32;
  localparam int unsigned STEP_W = 7;

  // dividends are left-aligned, so a short dividend takes only its own bit count
  localparam logic [STEP_W-1:0] RES_STEPS  = 7'd30;
  localparam logic [STEP_W-1:0] FULL_STEPS = 7'd64;

  localparam int unsigned OUT_DATA_W = 192;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_IRQ   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_NOT_STARTED = 2'd1,
    STS_ZERO_FREQ   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    DSRC_RES,
    DSRC_SEC,
    DSRC_NS
  } dsrc_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RES_LOAD,
    S_RES_WAIT,
    S_DISPATCH,
    S_TICK_WAIT,
    S_SEC_WAIT,
    S_MUL,
    S_NS_LOAD,
    S_NS_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    div_load;
    dsrc_e   div_sel;
    logic    res_store;
    logic    tick_mul;
    logic    start_upd;
    logic    irq_upd;
    logic    sec_store;
    logic    mul;
    logic    ns_store;
    logic    set_status;
    status_e status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       started;
    logic       freq_zero;
    logic       freq_res_ok;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage

// ----- sv/tick_compare_and_time_converter.sv -----
// Periodic timer compare and time converter for a free-running 64-bit timebase
// counter. A start item (tuser 0) captures the counter as the base and splits
// the frequency into a tick interval and a remainder; an interrupt item
// (tuser 1) advances the compare value; a read item (tuser 2) turns counter
// minus base into seconds and nanoseconds. Every item gives one result beat.
// One item is in work at a time. The divisions by the frequency share one
// restoring divider that yields one quotient bit per cycle, and the split by
// the tick rate is a multiplication by its reciprocal. An item is taken, then
// the resolution is found on the divider (skipped when the frequency is zero or
// above 1 GHz); a start then splits the frequency, an interrupt advances the
// compare value, and a read divides for seconds, multiplies the remainder and
// divides for nanoseconds. A result waits while the output register is full;
// a new item is taken while the previous result still waits in that register.
// ----------------------------------------------------------------------------
// tick_compare_and_time_converter
// Top level: sequencer, datapath and stream ports.
// ----------------------------------------------------------------------------
module tick_compare_and_time_converter import tctc_pkg::*; #(
  parameter int unsigned TICK_RATE = TICK_RATE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [31:0]           cfg_data_i,     // timebase_freq
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,   // raw_time
  input  logic [1:0]            s_axis_tuser,   // opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // compare_value [63:0], seconds [127:64], nanoseconds [157:128],
  // resolution_ns [187:158], zero fill [191:188]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser    // status
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tctc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tctc_datapath #(
    .TICK_RATE (TICK_RATE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .opcode_i    (s_axis_tuser),
    .raw_time_i  (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ----- sv/tctc_div.sv -----
// ----------------------------------------------------------------------------
// tctc_div
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
// ----------------------------------------------------------------------------
module tctc_div import tctc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [DVR_W-1:0]  divisor_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quot_o,
  output logic [DVR_W-1:0]  rem_o
);

  logic [STEP_W-1:0] cnt_q;
  logic [DIV_W-1:0]  q_q;
  logic [DVR_W-1:0]  r_q;
  logic [DVR_W-1:0]  d_q;
  logic [DVR_W:0]    r_sh;
  logic [DVR_W+1:0]  diff;

  assign r_sh = {r_q, q_q[DIV_W-1]};
  assign diff = {1'b0, r_sh} - {2'b00, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= steps_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!diff[DVR_W+1]) begin
        r_q <= diff[DVR_W-1:0];
        q_q <= {q_q[DIV_W-2:0], 1'b1};
      end else begin
        r_q <= r_sh[DVR_W-1:0];
        q_q <= {q_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

// ----- sv/tctc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tctc_ctrl
// Sequencer: steps one item through the shared divider and the update logic.
// ----------------------------------------------------------------------------
module tctc_ctrl import tctc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_RES_LOAD;
        end
      end
      S_RES_LOAD: begin
        // resolution stays zero for a frequency of zero or above 1 GHz
        if (sts_i.freq_res_ok) begin
          cmd_o.div_load = 1'b1;
          cmd_o.div_sel  = DSRC_RES;
          state_d        = S_RES_WAIT;
        end else begin
          state_d = S_DISPATCH;
        end
      end
      S_RES_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.res_store = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_OUT;
        unique case (sts_i.opcode)
          OP_START: begin
            if (sts_i.freq_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_ZERO_FREQ;
            end else begin
              cmd_o.tick_mul = 1'b1;
              state_d        = S_TICK_WAIT;
            end
          end
          OP_IRQ: begin
            if (!sts_i.started) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_NOT_STARTED;
            end else begin
              cmd_o.irq_upd = 1'b1;
            end
          end
          OP_READ: begin
            priority if (!sts_i.started) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_NOT_STARTED;
            end else if (sts_i.freq_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_ZERO_FREQ;
            end else begin
              cmd_o.div_load = 1'b1;
              cmd_o.div_sel  = DSRC_SEC;
              state_d        = S_SEC_WAIT;
            end
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_TICK_WAIT: begin
        cmd_o.start_upd = 1'b1;
        state_d         = S_OUT;
      end
      S_SEC_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.sec_store = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_NS_LOAD;
      end
      S_NS_LOAD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_sel  = DSRC_NS;
        state_d        = S_NS_WAIT;
      end
      S_NS_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.ns_store = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/tctc_datapath.sv -----
// ----------------------------------------------------------------------------
// tctc_datapath
// Frequency register, timer state, divider, multiplier and output register.
// ----------------------------------------------------------------------------
module tctc_datapath import tctc_pkg::*; #(
  parameter int unsigned TICK_RATE = TICK_RATE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [31:0]           cfg_data_i,
  input  logic [1:0]            opcode_i,
  input  logic [63:0]           raw_time_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic [1:0]            out_user_o
);

  localparam int unsigned CNT_W = (TICK_RATE > 1) ? $clog2(TICK_RATE) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TICK_RATE - 1);
  localparam logic [DVR_W-1:0] RATE_DVR = DVR_W'(TICK_RATE);
  // reciprocal of the tick rate, rounded up, exact for any 32-bit frequency
  localparam int unsigned RATE_SHIFT = (TICK_RATE > 1) ? $clog2(TICK_RATE) : 0;
  localparam logic [32:0] RATE_RECIP =
    33'(((65'd1 << (32 + RATE_SHIFT)) + 65'(TICK_RATE - 1)) / 65'(TICK_RATE));

  logic [31:0]      freq_q;
  logic             started_q;
  logic [63:0]      time_base_q;
  logic [63:0]      next_compare_q;
  logic [31:0]      interval_q;
  logic [CNT_W-1:0] remainder_q;
  logic [CNT_W-1:0] tick_count_q;
  logic             out_valid_q;

  logic [1:0]       opcode_q;
  logic [63:0]      raw_q;
  logic [29:0]      res_q;
  logic [63:0]      secs_q;
  logic [29:0]      nsec_q;
  status_e          status_q;
  logic [61:0]      prod_q;
  logic [31:0]      tick_quot_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [1:0]       out_user_q;

  logic             div_done;
  logic [DIV_W-1:0] div_quot;
  logic [DVR_W-1:0] div_rem;
  logic [DIV_W-1:0] div_dividend;
  logic [DVR_W-1:0] div_divisor;
  logic [STEP_W-1:0] div_steps;

  logic [64:0]      tick_prod;
  logic [31:0]      tick_rem;
  logic             tick_wrap;
  logic [32:0]      irq_step;

  always_comb begin
    unique case (cmd_i.div_sel)
      DSRC_RES: begin
        div_dividend = {NS_PER_SEC, 34'd0};
        div_divisor  = freq_q;
        div_steps    = RES_STEPS;
      end
      DSRC_SEC: begin
        div_dividend = raw_q - time_base_q;
        div_divisor  = freq_q;
        div_steps    = FULL_STEPS;
      end
      DSRC_NS: begin
        div_dividend = {2'b00, prod_q};
        div_divisor  = freq_q;
        div_steps    = FULL_STEPS;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = freq_q;
        div_steps    = FULL_STEPS;
      end
    endcase
  end

  tctc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.div_load),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // split by the tick rate: the quotient is registered, then the remainder is formed from it
  assign tick_prod = {33'd0, freq_q} * {32'd0, RATE_RECIP};
  assign tick_rem  = freq_q - tick_quot_q * RATE_DVR;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_mul) begin
      tick_quot_q <= 32'(tick_prod >> (32 + RATE_SHIFT));
    end
  end

  // remainder joins the interval once per TICK_RATE interrupts
  assign tick_wrap = (tick_count_q == CNT_LAST);
  assign irq_step  = {1'b0, interval_q}
                   + (tick_wrap ? 33'(remainder_q) : 33'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_RESET;
    end else if (cfg_valid_i) begin
      freq_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q      <= 1'b0;
      time_base_q    <= '0;
      next_compare_q <= '0;
      interval_q     <= '0;
      remainder_q    <= '0;
      tick_count_q   <= '0;
    end else if (cmd_i.start_upd) begin
      started_q      <= 1'b1;
      time_base_q    <= raw_q;
      next_compare_q <= raw_q + {32'd0, tick_quot_q};
      interval_q     <= tick_quot_q;
      remainder_q    <= tick_rem[CNT_W-1:0];
      tick_count_q   <= '0;
    end else if (cmd_i.irq_upd) begin
      next_compare_q <= next_compare_q + {31'd0, irq_step};
      tick_count_q   <= tick_wrap ? '0 : tick_count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q <= opcode_i;
      raw_q    <= raw_time_i;
      res_q    <= '0;
      secs_q   <= '0;
      nsec_q   <= '0;
      status_q <= STS_OK;
    end else begin
      if (cmd_i.res_store) begin
        res_q <= div_quot[29:0];
      end
      if (cmd_i.sec_store) begin
        secs_q <= div_quot;
      end
      if (cmd_i.ns_store) begin
        nsec_q <= div_quot[29:0];
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
    end
  end

  // remainder is below the frequency, so the product stays under 2^62
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 62'(div_rem) * 62'(NS_PER_SEC);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {4'd0, res_q, nsec_q, secs_q, next_compare_q};
      out_user_q <= status_q;
    end
  end

  assign sts_o.opcode      = opcode_q;
  assign sts_o.started     = started_q;
  assign sts_o.freq_zero   = (freq_q == '0);
  assign sts_o.freq_res_ok = (freq_q != '0) && (freq_q <= {2'b00, NS_PER_SEC});
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

// ----- sv/tctc_props.sv -----
// ----------------------------------------------------------------------------
// tctc_props
// Port-level properties of the timer block, bound to the top level.
// ----------------------------------------------------------------------------
`include "tick_compare_and_time_converter_defines.svh"

module tctc_props import tctc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  // stalled result beat holds
  `TCTC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready), (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

  // one item in work at a time
  `TCTC_ASSERT_NEXT(a_one_item, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready), (!s_axis_tready))

  `TCTC_ASSERT_NOW(a_ns_range, clk_i, rst_ni, (m_axis_tvalid), (m_axis_tdata[157:128] < 30'd1000000000))

  // a failed item reports no time
  `TCTC_ASSERT_NOW(a_err_no_time, clk_i, rst_ni, (m_axis_tvalid && (m_axis_tuser != STS_OK)), (m_axis_tdata[157:64] == '0))

endmodule

bind tick_compare_and_time_converter tctc_props u_props (.*);

// ----- dv/timer_result_checker.sv -----
// ----------------------------------------------------------------------------
// timer_result_checker
// Watches the config, item and result channels of the timer block, keeps its
// own copy of the timer state, predicts one result per accepted item and
// compares every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module timer_result_checker import tctc_pkg::*; #(
  parameter int unsigned TICK_RATE = TICK_RATE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [31:0]           cfg_data_i,     // timebase_freq
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,   // raw_time
  input  logic [1:0]            s_axis_tuser,   // opcode
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // compare_value [63:0], seconds [127:64], nanoseconds [157:128],
  // resolution_ns [187:158], zero fill [191:188]
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,   // status
  output int unsigned           fail_count_o,
  output int unsigned           pending_count_o
);

  typedef struct packed {
    logic [63:0] compare_value;
    logic [63:0] seconds;
    logic [29:0] nanoseconds;
    logic [29:0] resolution_ns;
    status_e     status;
  } timer_result_t;

  logic [31:0]   cur_freq;
  logic [63:0]   time_base;
  logic [63:0]   next_compare;
  logic [31:0]   tick_interval;
  logic [9:0]    carry_rem;
  logic [9:0]    tick_count;
  logic          model_started;
  timer_result_t expected_results[$];
  int unsigned   fails;
  int unsigned   beats_seen;

  function automatic timer_result_t advance_timer_model(input logic [1:0] op,
                                                       input logic [63:0] raw);
    timer_result_t res;
    logic [63:0]   elapsed;
    res = '0;
    res.status = STS_OK;
    case (op)
      OP_START: begin
        if (cur_freq == 32'd0) begin
          res.status = STS_ZERO_FREQ;
        end else begin
          time_base     = raw;
          tick_interval = cur_freq / TICK_RATE;
          carry_rem     = 10'(cur_freq % TICK_RATE);
          tick_count    = '0;
          next_compare  = raw + 64'(tick_interval);
          model_started = 1'b1;
        end
      end
      OP_IRQ: begin
        if (!model_started) begin
          res.status = STS_NOT_STARTED;
        end else begin
          next_compare = next_compare + 64'(tick_interval);
          // the remainder catches up once per full tick rate
          if (tick_count == 10'(TICK_RATE - 1)) begin
            tick_count   = '0;
            next_compare = next_compare + 64'(carry_rem);
          end else begin
            tick_count = tick_count + 10'd1;
          end
        end
      end
      OP_READ: begin
        if (!model_started) begin
          res.status = STS_NOT_STARTED;
        end else if (cur_freq == 32'd0) begin
          res.status = STS_ZERO_FREQ;
        end else begin
          elapsed           = raw - time_base;
          res.seconds       = elapsed / 64'(cur_freq);
          res.nanoseconds   = 30'(((elapsed % 64'(cur_freq)) * 64'(NS_PER_SEC))
                                  / 64'(cur_freq));
        end
      end
      default: ;
    endcase
    res.compare_value = next_compare;
    if (cur_freq != 32'd0 && cur_freq <= 32'(NS_PER_SEC)) begin
      res.resolution_ns = 30'(32'(NS_PER_SEC) / cur_freq);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst_ni) begin
      cur_freq      = FREQ_RESET;
      time_base     = '0;
      next_compare  = '0;
      tick_interval = '0;
      carry_rem     = '0;
      tick_count    = '0;
      model_started = 1'b0;
      fails         = 0;
      beats_seen    = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        cur_freq = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beats_seen++;
        got.compare_value = m_axis_tdata[63:0];
        got.seconds       = m_axis_tdata[127:64];
        got.nanoseconds   = m_axis_tdata[157:128];
        got.resolution_ns = m_axis_tdata[187:158];
        got.status        = status_e'(m_axis_tuser);
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("result beat %0d arrived with nothing outstanding: cmp %h sts %0d",
                     beats_seen, got.compare_value, got.status);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.compare_value !== want.compare_value || got.seconds !== want.seconds ||
              got.nanoseconds !== want.nanoseconds ||
              got.resolution_ns !== want.resolution_ns || got.status !== want.status) begin
            fails++;
            if (fails <= 10) begin
              $display("beat %0d mismatch (exp/act): cmp %h/%h sec %h/%h", beats_seen,
                       want.compare_value, got.compare_value, want.seconds, got.seconds);
              $display("  ns %0d/%0d res %0d/%0d sts %0d/%0d", want.nanoseconds,
                       got.nanoseconds, want.resolution_ns, got.resolution_ns,
                       want.status, got.status);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(advance_timer_model(s_axis_tuser, s_axis_tdata));
      end
    end
    fail_count_o    <= fails;
    pending_count_o <= expected_results.size();
  end

endmodule

// ----- dv/tick_compare_and_time_converter_test.sv -----
// ----------------------------------------------------------------------------
// tick_compare_and_time_converter_test
// Drives start, interrupt, read and unused items into the timer block under a
// series of frequency settings, with random gaps and stalls on both streams
// and one long output stall; the checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tick_compare_and_time_converter_test;
  import tctc_pkg::*;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned ITEM_TARGET    = 1850;
  localparam int unsigned CALM_FROM      = ITEM_TARGET - 250;
  localparam int unsigned TICK_RUN_LEN   = 1150;
  localparam int unsigned LONG_STALL     = 400;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned TIMEOUT_CYCLES = 1_600_000;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [31:0]           cfg_data_i;     // timebase_freq
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata;   // raw_time
  logic [1:0]            s_axis_tuser;   // opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // compare_value [63:0], seconds [127:64], nanoseconds [157:128],
  // resolution_ns [187:158], zero fill [191:188]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;   // status

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned items_sent;
  bit          calm;
  bit          stall_req;
  logic [31:0] freq_now;
  logic [63:0] base_guess;

  tick_compare_and_time_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  timer_result_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [63:0] raw);
    calm = (items_sent >= CALM_FROM);
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (op == OP_START && freq_now != 32'd0) begin
      base_guess = raw;
    end
  endtask

  // only while nothing is in flight
  task automatic write_freq(input logic [31:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    freq_now = value;
  endtask

  // mostly short spans past the captured base, sometimes anything at all
  function automatic logic [63:0] pick_read_time();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    if (sel < 2) return base_guess + 64'($urandom);
    if (sel == 2) return base_guess + {$urandom, $urandom};
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_freq();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd999;
      3:       return 32'd1000;
      4:       return 32'(NS_PER_SEC);
      5:       return 32'(NS_PER_SEC) + 32'd1;
      6:       return 32'hFFFF_FFFF;
      7:       return $urandom_range(1001, 100_000);
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      if (stall_req) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk_i);
        stall_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned seg_len;
    int unsigned pick;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    items_sent    = 0;
    calm          = 1'b0;
    stall_req     = 1'b0;
    freq_now      = FREQ_RESET;
    base_guess    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // everything before the first start is refused, unused opcode is harmless
    send_item(OP_IRQ, {$urandom, $urandom});
    send_item(OP_READ, {$urandom, $urandom});
    send_item(OP_UNUSED, '1);
    // base near the top so the compare value wraps
    send_item(OP_START, 64'hFFFF_FFFF_FFFF_FF00);
    send_item(OP_IRQ, '0);
    send_item(OP_READ, 64'hFFFF_FFFF_FFFF_FF00 + 64'd25_000_000);
    send_item(OP_READ, '0);
    send_item(OP_UNUSED, '0);
    // zero frequency: start refused, interrupts keep the old interval
    write_freq(32'd0);
    send_item(OP_START, {$urandom, $urandom});
    send_item(OP_READ, {$urandom, $urandom});
    send_item(OP_IRQ, '1);
    write_freq(32'hFFFF_FFFF);
    send_item(OP_START, '0);
    send_item(OP_READ, '1);
    send_item(OP_IRQ, '0);
    // frequency changed after start, just above and at one gigahertz
    write_freq(32'(NS_PER_SEC) + 32'd1);
    send_item(OP_READ, {$urandom, $urandom});
    write_freq(32'(NS_PER_SEC));
    send_item(OP_READ, {$urandom, $urandom});
    write_freq(32'd1);
    send_item(OP_START, '1);
    send_item(OP_READ, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(OP_IRQ, '1);
    // interval of zero, remainder only
    write_freq(32'd999);
    send_item(OP_START, {$urandom, $urandom});
    send_item(OP_IRQ, '0);
    send_item(OP_IRQ, '0);
    write_freq(32'd1000);
    send_item(OP_START, {$urandom, $urandom});
    send_item(OP_READ, pick_read_time());

    // one long interrupt run that crosses the remainder catch-up
    write_freq($urandom_range(2_000_000, 32'hFFFF_FFFF));
    send_item(OP_START, {$urandom, $urandom});
    for (n = 0; n < TICK_RUN_LEN; n++) begin
      if (n == 100) stall_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 96) send_item(OP_IRQ, {$urandom, $urandom});
      else if (pick < 99) send_item(OP_READ, pick_read_time());
      else send_item(OP_UNUSED, {$urandom, $urandom});
    end

    // short phases over many frequency settings
    while (items_sent < ITEM_TARGET) begin
      write_freq(pick_freq());
      send_item(OP_START, {$urandom, $urandom});
      seg_len = $urandom_range(30, 80);
      for (n = 0; n < seg_len && items_sent < ITEM_TARGET; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) send_item(OP_START, {$urandom, $urandom});
        else if (pick < 50) send_item(OP_IRQ, {$urandom, $urandom});
        else if (pick < 92) send_item(OP_READ, pick_read_time());
        else send_item(OP_UNUSED, {$urandom, $urandom});
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- tick_compare_and_time_converter.f -----
+incdir+sv
sv/tctc_pkg.sv
sv/tctc_div.sv
sv/tctc_ctrl.sv
sv/tctc_datapath.sv
sv/tick_compare_and_time_converter.sv
sv/tctc_props.sv
dv/timer_result_checker.sv
dv/tick_compare_and_time_converter_test.sv
